// ----- hw/rtl/gsfc_pkg.sv -----
// Package for the gas sensor frame codec: codes, reset values and the queue entry type.
// No dependencies; imported by every module of the block.
package gsfc_pkg;

    localparam logic       OP_SEND  = 1'b0;
    localparam logic       OP_RECV  = 1'b1;

    localparam logic       KIND_TX      = 1'b0;
    localparam logic       KIND_READING = 1'b1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_START = 2'd1;
    localparam logic [1:0] STATUS_BAD_CMD   = 2'd2;
    localparam logic [1:0] STATUS_BAD_SUM   = 2'd3;

    localparam logic [1:0] CFG_START_BYTE    = 2'd0;
    localparam logic [1:0] CFG_SENSOR_NUMBER = 2'd1;
    localparam logic [1:0] CFG_READ_COMMAND  = 2'd2;

    localparam logic [7:0] START_BYTE_RST    = 8'd255;
    localparam logic [7:0] SENSOR_NUMBER_RST = 8'd1;
    localparam logic [7:0] READ_COMMAND_RST  = 8'd134;

    // Frame byte positions
    localparam logic [3:0] POS_START = 4'd0;
    localparam logic [3:0] POS_ADDR  = 4'd1;
    localparam logic [3:0] POS_CMD   = 4'd2;
    localparam logic [3:0] POS_ARG   = 4'd3;
    localparam logic [3:0] POS_SUM   = 4'd8;

    localparam int QUEUE_DEPTH_DEF = 4;

    typedef struct packed {
        logic       is_reading;
        logic [7:0] start;
        logic [7:0] addr;
        logic [7:0] cmd;
        logic [7:0] arg;
        logic [7:0] csum;
        logic [15:0] reading;
        logic [1:0] status;
    } job_t;

endpackage

// ----- hw/rtl/gsfc_front.sv -----
// Front end of the frame codec: configuration registers, receive framing state and job build.
// Depends on gsfc_pkg.
module gsfc_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic          op,
    input  logic [7:0]    cmd_code,
    input  logic [7:0]    arg_byte,
    input  logic [7:0]    rx_byte,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [7:0]    cfg_data,
    input  logic          q_full,
    output logic          push,
    output gsfc_pkg::job_t push_job
);
    import gsfc_pkg::*;

    logic [7:0]  start_reg, start_next;
    logic [7:0]  sensor_reg, sensor_next;
    logic [7:0]  rdcmd_reg, rdcmd_next;
    logic [3:0]  rx_pos_reg, rx_pos_next;
    logic [7:0]  rx_sum_reg, rx_sum_next;
    logic [15:0] rx_value_reg, rx_value_next;
    logic [1:0]  rx_error_reg, rx_error_next;
    logic        accept;
    logic [7:0]  tx_sum;
    logic [7:0]  expect_sum;
    logic [1:0]  final_status;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;
    assign accept    = in_valid && !q_full;

    assign tx_sum       = sensor_reg + cmd_code + arg_byte;
    assign expect_sum   = 8'd0 - rx_sum_reg;
    assign final_status = (rx_error_reg == STATUS_OK && rx_byte != expect_sum)
                          ? STATUS_BAD_SUM : rx_error_reg;

    always_comb
    begin
        start_next  = start_reg;
        sensor_next = sensor_reg;
        rdcmd_next  = rdcmd_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_START_BYTE:    start_next  = cfg_data;
                CFG_SENSOR_NUMBER: sensor_next = cfg_data;
                CFG_READ_COMMAND:  rdcmd_next  = cfg_data;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        rx_pos_next   = rx_pos_reg;
        rx_sum_next   = rx_sum_reg;
        rx_value_next = rx_value_reg;
        rx_error_next = rx_error_reg;
        push          = 1'b0;

        push_job.is_reading = (op == OP_RECV);
        push_job.start      = start_reg;
        push_job.addr       = sensor_reg;
        push_job.cmd        = cmd_code;
        push_job.arg        = arg_byte;
        push_job.csum       = 8'd0 - tx_sum;
        push_job.reading    = (final_status == STATUS_OK) ? rx_value_reg : 16'd0;
        push_job.status     = final_status;

        if (accept)
        begin
            if (op == OP_SEND)
            begin
                push          = 1'b1;
                rx_pos_next   = POS_START;
                rx_sum_next   = 8'd0;
                rx_value_next = 16'd0;
                rx_error_next = STATUS_OK;
            end
            else if (rx_pos_reg == POS_SUM)
            begin
                push          = 1'b1;
                rx_pos_next   = POS_START;
                rx_sum_next   = 8'd0;
                rx_value_next = 16'd0;
                rx_error_next = STATUS_OK;
            end
            else
            begin
                rx_pos_next = rx_pos_reg + 4'd1;
                if (rx_pos_reg == POS_START)
                begin
                    if (rx_byte != start_reg)
                        rx_error_next = STATUS_BAD_START;
                end
                else
                begin
                    rx_sum_next = rx_sum_reg + rx_byte;
                    if (rx_pos_reg == POS_ADDR && rx_byte != rdcmd_reg
                        && rx_error_reg == STATUS_OK)
                        rx_error_next = STATUS_BAD_CMD;
                    if (rx_pos_reg == POS_CMD)
                        rx_value_next = {rx_byte, rx_value_reg[7:0]};
                    else if (rx_pos_reg == POS_ARG)
                        rx_value_next = {rx_value_reg[15:8], rx_byte};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg    <= START_BYTE_RST;
            sensor_reg   <= SENSOR_NUMBER_RST;
            rdcmd_reg    <= READ_COMMAND_RST;
            rx_pos_reg   <= POS_START;
            rx_sum_reg   <= 8'd0;
            rx_value_reg <= 16'd0;
            rx_error_reg <= STATUS_OK;
        end
        else
        begin
            start_reg    <= start_next;
            sensor_reg   <= sensor_next;
            rdcmd_reg    <= rdcmd_next;
            rx_pos_reg   <= rx_pos_next;
            rx_sum_reg   <= rx_sum_next;
            rx_value_reg <= rx_value_next;
            rx_error_reg <= rx_error_next;
        end
    end

endmodule

// ----- hw/rtl/gsfc_queue.sv -----
// Short job queue between the front end and the output sequencer.
// Depends on gsfc_pkg; DEPTH must be a power of two, at least 2.
module gsfc_queue
#(
    parameter int DEPTH = gsfc_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  gsfc_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output gsfc_pkg::job_t head_job,
    output logic           empty
);
    import gsfc_pkg::*;

    localparam int AW = $clog2(DEPTH);

    job_t        slot_reg [DEPTH];
    logic [AW:0] wr_ptr_reg, wr_ptr_next;
    logic [AW:0] rd_ptr_reg, rd_ptr_next;

    assign empty = (wr_ptr_reg == rd_ptr_reg);
    assign full  = (wr_ptr_reg[AW] != rd_ptr_reg[AW])
                   && (wr_ptr_reg[AW-1:0] == rd_ptr_reg[AW-1:0]);
    assign head_job = slot_reg[rd_ptr_reg[AW-1:0]];

    assign wr_ptr_next = wr_ptr_reg + {{AW{1'b0}}, (push && !full)};
    assign rd_ptr_next = rd_ptr_reg + {{AW{1'b0}}, (pop && !empty)};

    always_ff @(posedge clk)
    begin
        if (push && !full)
            slot_reg[wr_ptr_reg[AW-1:0]] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

endmodule

// ----- hw/rtl/gsfc_back.sv -----
// Output sequencer: expands queued jobs into transmit bytes or a reading result.
// Depends on gsfc_pkg.
module gsfc_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  gsfc_pkg::job_t head_job,
    input  logic           empty,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_stall,
    output logic           kind,
    output logic [7:0]     tx_byte,
    output logic           last,
    output logic [15:0]    reading,
    output logic [1:0]     status
);
    import gsfc_pkg::*;

    logic        out_valid_reg, out_valid_next;
    logic        kind_reg, kind_next;
    logic [7:0]  tx_reg, tx_next;
    logic        last_reg, last_next;
    logic [15:0] reading_reg, reading_next;
    logic [1:0]  status_reg, status_next;
    logic [3:0]  byte_idx_reg, byte_idx_next;
    logic        advance;
    logic [7:0]  frame_byte;

    assign advance = !out_valid_reg || !out_stall;

    always_comb
    begin
        case (byte_idx_reg)
            POS_START: frame_byte = head_job.start;
            POS_ADDR:  frame_byte = head_job.addr;
            POS_CMD:   frame_byte = head_job.cmd;
            POS_ARG:   frame_byte = head_job.arg;
            POS_SUM:   frame_byte = head_job.csum;
            default:   frame_byte = 8'd0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        tx_next        = tx_reg;
        last_next      = last_reg;
        reading_next   = reading_reg;
        status_next    = status_reg;
        byte_idx_next  = byte_idx_reg;
        pop            = 1'b0;
        if (advance)
        begin
            out_valid_next = !empty;
            if (!empty)
            begin
                if (head_job.is_reading)
                begin
                    kind_next    = KIND_READING;
                    tx_next      = 8'd0;
                    last_next    = 1'b1;
                    reading_next = head_job.reading;
                    status_next  = head_job.status;
                    pop          = 1'b1;
                end
                else
                begin
                    kind_next    = KIND_TX;
                    tx_next      = frame_byte;
                    last_next    = (byte_idx_reg == POS_SUM);
                    reading_next = 16'd0;
                    status_next  = STATUS_OK;
                    if (byte_idx_reg == POS_SUM)
                    begin
                        pop           = 1'b1;
                        byte_idx_next = POS_START;
                    end
                    else
                        byte_idx_next = byte_idx_reg + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            byte_idx_reg  <= POS_START;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            byte_idx_reg  <= byte_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        tx_reg      <= tx_next;
        last_reg    <= last_next;
        reading_reg <= reading_next;
        status_reg  <= status_next;
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign tx_byte   = tx_reg;
    assign last      = last_reg;
    assign reading   = reading_reg;
    assign status    = status_reg;

endmodule

// ----- hw/rtl/gas_sensor_frame_codec.sv -----
// Top level of the gas sensor 9-byte frame codec.
// Depends on gsfc_pkg, gsfc_front, gsfc_queue and gsfc_back.
//
// Input channel (in_valid/in_stall): op 0 sends a command frame, op 1 hands in one
// received response byte. Output channel (out_valid/out_stall): a send gives nine
// transmit bytes (kind 0, last on the checksum); the ninth received byte gives one
// reading result (kind 1) with its status. Other received bytes give nothing.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 start byte,
// 1 sensor number, 2 expected read command; index 3 is ignored. Write only when idle.
// An accepted input is first written into the job queue and only then loaded into the
// output register that drives out_valid and the output fields.
// Throughput: one input per cycle while the job queue has room; the output register
// delivers one result per cycle while out_stall is low, so a send holds the output for
// all nine transmit bytes and the queue (QUEUE_DEPTH jobs) fills behind it. Received
// bytes that produce no result never wait on the output side unless the queue is full.
// Reset: registers return to 0xFF / 0x01 / 0x86, receiver restarts at byte 0, the
// queue empties. A stalled output holds its transaction; the front keeps accepting
// until the queue is full, then raises in_stall.
module gas_sensor_frame_codec
#(
    parameter int QUEUE_DEPTH = gsfc_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [7:0]  cmd_code,
    input  logic [7:0]  arg_byte,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        kind,
    output logic [7:0]  tx_byte,
    output logic        last,
    output logic [15:0] reading,
    output logic [1:0]  status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import gsfc_pkg::*;

    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    job_t push_job;
    job_t head_job;

    gsfc_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .cmd_code  (cmd_code),
        .arg_byte  (arg_byte),
        .rx_byte   (rx_byte),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .push      (push),
        .push_job  (push_job)
    );

    gsfc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .head_job (head_job),
        .empty    (q_empty)
    );

    gsfc_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_job  (head_job),
        .empty     (q_empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .tx_byte   (tx_byte),
        .last      (last),
        .reading   (reading),
        .status    (status)
    );

endmodule
